FILE: rtl/core/i2ctbe_pkg.sv
// Package for the I2C target byte engine: shared widths, phase, event and
// SCL class codes, and the state and result structs.
// No dependencies.
package i2ctbe_pkg;

  localparam int unsigned AddrBits  = 7;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned CountBits = 4;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = AddrBits;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEnabled    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgOwnAddress = 1'd1;

  // Bus phase, one-hot
  typedef enum logic [7:0] {
    PhIdle     = 8'b0000_0001,
    PhStarted  = 8'b0000_0010,
    PhReceive  = 8'b0000_0100,
    PhTransmit = 8'b0000_1000,
    PhAckDue   = 8'b0001_0000,
    PhAckHeld  = 8'b0010_0000,
    PhWaitAck  = 8'b0100_0000,
    PhStopped  = 8'b1000_0000
  } phase_e;

  typedef enum logic [3:0] {
    EvNone     = 4'd0,
    EvStart    = 4'd1,
    EvStop     = 4'd2,
    EvAddrW    = 4'd3,
    EvAddrR    = 4'd4,
    EvByte     = 4'd5,
    EvAck      = 4'd6,
    EvNack     = 4'd7,
    EvMismatch = 4'd8
  } event_e;

  typedef enum logic [1:0] {
    SclHigh    = 2'd0,
    SclRise    = 2'd1,
    SclFall    = 2'd2,
    SclLow     = 2'd3
  } scl_e;

  typedef struct packed {
    phase_e                phase;
    phase_e                ret_phase;
    logic [CountBits-1:0]  bit_count;
    logic [ByteBits-1:0]   shift_in;
    logic [ByteBits-1:0]   shift_out;
    logic                  prev_sda;
    logic                  drive_low;
  } state_t;

  typedef struct packed {
    logic                  drive_low;
    event_e                ev;
    logic [ByteBits-1:0]   rx_byte;
  } result_t;

endpackage

FILE: rtl/core/i2ctbe_step.sv
// Next-state and result logic for one bus sample of the I2C target.
// Purely combinational; depends on i2ctbe_pkg.
module i2ctbe_step
  import i2ctbe_pkg::*;
(
  input  state_t                 state_i,
  input  logic                   enabled_i,
  input  logic [AddrBits-1:0]    own_address_i,
  input  logic [1:0]             scl_event_i,
  input  logic                   sda_i,
  input  logic [ByteBits-1:0]    tx_byte_i,
  output state_t                 state_o,
  output result_t                result_o
);

  // Shift one received bit in; the first bit of a frame is not shifted
  function automatic logic [ByteBits-1:0] shift_bit(
    input logic [ByteBits-1:0]  si,
    input logic [CountBits-1:0] bc,
    input logic                 b
  );
    logic [ByteBits-1:0] base;
    base = (bc != '0) ? {si[ByteBits-2:0], 1'b0} : si;
    return base + {{(ByteBits-1){1'b0}}, b};
  endfunction

  always_comb begin
    state_t               s;
    event_e               ev;
    logic [ByteBits-1:0]  rx;
    logic                 rw;
    s  = state_i;
    ev = EvNone;
    rx = '0;
    rw = 1'b0;

    if (enabled_i) begin
      case (scl_e'(scl_event_i))
        // Detect start and stop while SCL stays high, unless an ack is due
        SclHigh: begin
          if (s.phase != PhAckDue) begin
            if (!sda_i && s.prev_sda) begin
              s.bit_count = '0;
              s.shift_in  = '0;
              s.phase     = PhStarted;
              ev          = EvStart;
            end else if (sda_i && !s.prev_sda) begin
              s.phase = PhStopped;
              ev      = EvStop;
            end
          end
        end
        // Sample address, write data and controller acknowledge
        SclRise: begin
          case (s.phase)
            PhStarted: begin
              s.shift_in  = shift_bit(s.shift_in, s.bit_count, sda_i);
              s.bit_count = s.bit_count + 1'b1;
              if (s.bit_count > CountBits'(AddrBits)) begin
                rw         = s.shift_in[0];
                s.shift_in = s.shift_in >> 1;
                if (s.shift_in == {1'b0, own_address_i}) begin
                  if (rw) begin
                    s.phase     = PhTransmit;
                    s.shift_out = tx_byte_i;
                    s.bit_count = CountBits'(ByteBits - 1);
                    ev          = EvAddrR;
                  end else begin
                    s.phase     = PhReceive;
                    s.bit_count = '0;
                    ev          = EvAddrW;
                  end
                  s.ret_phase = s.phase;
                  s.phase     = PhAckDue;
                end else begin
                  s.phase    = PhStopped;
                  s.shift_in = '0;
                  ev         = EvMismatch;
                end
              end
            end
            PhReceive: begin
              s.shift_in  = shift_bit(s.shift_in, s.bit_count, sda_i);
              s.bit_count = s.bit_count + 1'b1;
              if (s.bit_count == CountBits'(ByteBits)) begin
                s.bit_count = '0;
                s.ret_phase = s.phase;
                s.phase     = PhAckDue;
                ev          = EvByte;
                rx          = s.shift_in;
              end
            end
            PhWaitAck: begin
              if (!sda_i) begin
                s.phase     = s.ret_phase;
                s.shift_out = tx_byte_i;
                s.bit_count = CountBits'(ByteBits - 1);
                ev          = EvAck;
              end else begin
                s.phase = PhIdle;
                ev      = EvNack;
              end
            end
            default: begin
            end
          endcase
        end
        // Drive own acknowledge and shift out read data
        SclFall: begin
          if (s.phase == PhAckDue) begin
            s.drive_low = 1'b1;
            s.phase     = PhAckHeld;
          end else if (s.phase == PhAckHeld) begin
            s.drive_low = 1'b0;
            s.phase     = s.ret_phase;
            s.shift_in  = '0;
          end
          if (s.phase == PhTransmit) begin
            if (s.bit_count > CountBits'(ByteBits - 1)) begin
              s.drive_low = 1'b0;
              s.ret_phase = s.phase;
              s.phase     = PhWaitAck;
            end else begin
              s.drive_low = ~s.shift_out[s.bit_count[2:0]];
              s.bit_count = s.bit_count - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      s.prev_sda = sda_i;
    end

    state_o           = s;
    result_o.drive_low = s.drive_low;
    result_o.ev        = ev;
    result_o.rx_byte   = rx;
  end

endmodule

FILE: rtl/core/i2ctbe_out_reg.sv
// Result register of the I2C target: holds one result until it is taken
// and lets a new transaction in while the held one leaves. Uses i2ctbe_pkg.
module i2ctbe_out_reg
  import i2ctbe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  result_t  result_i,
  input  logic     out_ready_i,
  output logic     space_o,
  output logic     out_valid_o,
  output result_t  result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // Free when empty or when the held result is taken this cycle
  assign space_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

FILE: rtl/core/i2ctbe_byte_engine_top_note.sv
// Bus state register bank of the I2C target: holds phase, counters, shift
// registers and line drive, updated on each accepted sample. Uses i2ctbe_pkg.
module i2ctbe_state_reg
  import i2ctbe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  state_t  state_i,
  output state_t  state_o
);

  state_t state_q;

  // Advance the bus state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PhIdle;
      state_q.ret_phase <= PhIdle;
      state_q.bit_count <= '0;
      state_q.shift_in  <= '0;
      state_q.shift_out <= '0;
      state_q.prev_sda  <= 1'b0;
      state_q.drive_low <= 1'b0;
    end else if (load_i) begin
      state_q <= state_i;
    end
  end

  assign state_o = state_q;

  // An acknowledge in progress always holds the line low
  a_ack_held_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PhAckHeld |-> state_q.drive_low)
    else $error("ack held without driving SDA low");

  // Waiting for the controller acknowledge leaves the line released
  a_wait_ack_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PhWaitAck |-> !state_q.drive_low)
    else $error("waiting for controller ack while SDA driven");

  // The transmit counter sits in range or at the wrap value
  a_tx_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PhTransmit |->
      (state_q.bit_count <= CountBits'(ByteBits - 1) || state_q.bit_count == '1))
    else $error("transmit bit counter out of range");

endmodule

FILE: rtl/core/i2c_target_byte_engine.sv
// Top level of the I2C target byte engine: configuration registers, bus
// state, step logic and result register. Uses i2ctbe_pkg, i2ctbe_step,
// i2ctbe_state_reg and i2ctbe_out_reg.
//
//   channel  handshake               payload
//   -------  ----------------------  ------------------------------------
//   in       in_valid_i / in_ready_o  scl_event_i, sda_i, tx_byte_i
//   out      out_valid_o / out_ready_i sda_drive_low_o, event_res_o, rx_byte_o
//   cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_wdata_i
//
// One sample per cycle while the output is not stalled: the step logic runs
// between the bus state and result registers, so a result is valid in the next cycle.
// in_ready_o is high while the result register is empty or being emptied.
// A stalled output holds its result and stops new samples, nothing else.
// Reset leaves the target enabled, address 0, phase idle, state SDA drive released.
// Configuration writes are always taken.
module i2c_target_byte_engine
  import i2ctbe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           scl_event_i,
  input  logic                 sda_i,
  input  logic [ByteBits-1:0]  tx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 sda_drive_low_o,
  output logic [3:0]           event_res_o,
  output logic [ByteBits-1:0]  rx_byte_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  logic                enabled_q;
  logic [AddrBits-1:0] own_address_q;
  logic                accept;
  logic                space;
  state_t              state_cur, state_nxt;
  result_t             res_nxt, res_out;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q     <= 1'b1;
      own_address_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgEnabled:    enabled_q     <= cfg_wdata_i[0];
        CfgOwnAddress: own_address_q <= cfg_wdata_i[AddrBits-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  i2ctbe_state_reg u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .state_i (state_nxt),
    .state_o (state_cur)
  );

  i2ctbe_step u_step (
    .state_i       (state_cur),
    .enabled_i     (enabled_q),
    .own_address_i (own_address_q),
    .scl_event_i   (scl_event_i),
    .sda_i         (sda_i),
    .tx_byte_i     (tx_byte_i),
    .state_o       (state_nxt),
    .result_o      (res_nxt)
  );

  i2ctbe_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (res_nxt),
    .out_ready_i (out_ready_i),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .result_o    (res_out)
  );

  assign sda_drive_low_o = res_out.drive_low;
  assign event_res_o     = res_out.ev;
  assign rx_byte_o       = res_out.rx_byte;

  // Every accepted sample yields a result on the next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted sample produced no result");

  // A disabled target reports no event
  a_disabled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !enabled_q |=> event_res_o == EvNone)
    else $error("event reported while disabled");

  // The received byte is zero except with a byte event
  a_rx_only_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EvByte |-> rx_byte_o == '0)
    else $error("rx byte set without byte event");

endmodule

FILE: tb/sv/i2c_target_byte_engine_test.sv
// Testbench for the I2C target byte engine: drives bus samples through the
// input channel, predicts every result and checks it field by field.
// Depends on i2ctbe_pkg and i2c_target_byte_engine.
`timescale 1ns / 1ps

module i2c_target_byte_engine_test;
  import i2ctbe_pkg::*;

  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned RoundItems   = 30;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           scl_event_i = SclHigh;
  logic                 sda_i = 1'b0;
  logic [ByteBits-1:0]  tx_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 sda_drive_low_o;
  logic [3:0]           event_res_o;
  logic [ByteBits-1:0]  rx_byte_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;

  // Predictor copy of the configuration and bus state
  logic                 cfg_en = 1'b1;
  logic [AddrBits-1:0]  cfg_addr = '0;
  phase_e               bus_phase = PhIdle;
  phase_e               resume_phase = PhIdle;
  logic [CountBits-1:0] bit_cnt = '0;
  logic [ByteBits-1:0]  rx_shift = '0;
  logic [ByteBits-1:0]  tx_shift = '0;
  logic                 last_sda = 1'b0;
  logic                 pull_low = 1'b0;

  result_t     awaited_results[$];
  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  int unsigned result_count = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_out = 1'b0;

  i2c_target_byte_engine DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .scl_event_i,
    .sda_i,
    .tx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .sda_drive_low_o,
    .event_res_o,
    .rx_byte_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length for either side: mostly none, some short, a few long
  function automatic int unsigned draw_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             result_count, what, got, want);
  endtask

  // Shift one received bit into the byte register, MSB first
  task automatic shift_rx_bit(input logic b);
    if (bit_cnt != 0) rx_shift = rx_shift << 1;
    rx_shift = rx_shift + {7'd0, b};
    bit_cnt = bit_cnt + 1'b1;
  endtask

  // Drive the next read bit, or release and wait for the controller ack
  task automatic shift_tx_bit();
    if (bit_cnt > 4'd7) begin
      pull_low = 1'b0;
      resume_phase = bus_phase;
      bus_phase = PhWaitAck;
    end else begin
      pull_low = ~tx_shift[bit_cnt[2:0]];
      bit_cnt = bit_cnt - 1'b1;
    end
  endtask

  // Advance the predicted target by one bus sample and queue its result
  task automatic predict_sample_result(input scl_e scl, input logic sda,
                                       input logic [7:0] tx);
    event_e         ev;
    logic [7:0]     rx;
    logic           rw;
    result_t        res;
    ev = EvNone;
    rx = '0;
    if (!cfg_en) begin
      res.drive_low = pull_low;
      res.ev = EvNone;
      res.rx_byte = '0;
      awaited_results.push_back(res);
      return;
    end
    case (scl)
      SclHigh: begin
        if (bus_phase != PhAckDue) begin
          if (!sda && last_sda) begin
            bit_cnt = '0;
            rx_shift = '0;
            bus_phase = PhStarted;
            ev = EvStart;
          end else if (sda && !last_sda) begin
            bus_phase = PhStopped;
            ev = EvStop;
          end
        end
      end
      SclRise: begin
        if (bus_phase == PhStarted) begin
          shift_rx_bit(sda);
          if (bit_cnt > AddrBits) begin
            rw = rx_shift[0];
            rx_shift = rx_shift >> 1;
            if (rx_shift == {1'b0, cfg_addr}) begin
              if (rw) begin
                bus_phase = PhTransmit;
                tx_shift = tx;
                bit_cnt = 4'd7;
                ev = EvAddrR;
              end else begin
                bus_phase = PhReceive;
                bit_cnt = '0;
                ev = EvAddrW;
              end
              resume_phase = bus_phase;
              bus_phase = PhAckDue;
            end else begin
              bus_phase = PhStopped;
              rx_shift = '0;
              ev = EvMismatch;
            end
          end
        end else if (bus_phase == PhReceive) begin
          shift_rx_bit(sda);
          if (bit_cnt == 4'd8) begin
            bit_cnt = '0;
            resume_phase = bus_phase;
            bus_phase = PhAckDue;
            ev = EvByte;
            rx = rx_shift;
          end
        end else if (bus_phase == PhWaitAck) begin
          if (!sda) begin
            bus_phase = resume_phase;
            tx_shift = tx;
            bit_cnt = 4'd7;
            ev = EvAck;
          end else begin
            bus_phase = PhIdle;
            ev = EvNack;
          end
        end
      end
      SclFall: begin
        if (bus_phase == PhAckDue) begin
          pull_low = 1'b1;
          bus_phase = PhAckHeld;
        end else if (bus_phase == PhAckHeld) begin
          pull_low = 1'b0;
          bus_phase = resume_phase;
          rx_shift = '0;
        end
        if (bus_phase == PhTransmit) shift_tx_bit();
      end
      default: ;
    endcase
    last_sda = sda;
    res.drive_low = pull_low;
    res.ev = ev;
    res.rx_byte = rx;
    awaited_results.push_back(res);
  endtask

  // Check each result, predict each accepted sample, track register writes
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, event", {4'd0, event_res_o}, 8'd0);
        end else begin
          want = awaited_results.pop_front();
          if (sda_drive_low_o !== want.drive_low)
            report_mismatch("sda_drive_low", {7'd0, sda_drive_low_o},
                            {7'd0, want.drive_low});
          if (event_res_o !== want.ev)
            report_mismatch("event_res", {4'd0, event_res_o}, {4'd0, want.ev});
          if (rx_byte_o !== want.rx_byte)
            report_mismatch("rx_byte", rx_byte_o, want.rx_byte);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgEnabled:    cfg_en = cfg_wdata_i[0];
          CfgOwnAddress: cfg_addr = cfg_wdata_i[AddrBits-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        predict_sample_result(scl_e'(scl_event_i), sda_i, tx_byte_i);
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("** i2c_target_byte_engine: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_out = 1'b0;
      end else begin
        gap = draw_gap();
        if (gap == 0) begin
          out_ready_i = 1'b1;
        end else begin
          out_ready_i = 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Offer one bus sample and hold it until the transaction completes
  task automatic send_sample(input scl_e scl, input logic sda, input logic [7:0] tx);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    scl_event_i = scl;
    sda_i       = sda;
    tx_byte_i   = tx;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
  endtask

  task automatic drive_bus(input scl_e scl, input logic sda);
    send_sample(scl, sda, 8'($urandom));
  endtask

  // One SCL clock for a data bit; the compact form skips the steady levels
  task automatic clock_bit(input logic b, input bit compact);
    if (!compact) drive_bus(SclLow, b);
    drive_bus(SclRise, b);
    if (!compact) drive_bus(SclHigh, b);
    drive_bus(SclFall, b);
  endtask

  task automatic clock_byte(input logic [7:0] value, input bit compact);
    for (int i = 7; i >= 0; i--) clock_bit(value[i], compact);
  endtask

  task automatic bus_start();
    drive_bus(SclHigh, 1'b1);
    drive_bus(SclHigh, 1'b0);
    drive_bus(SclFall, 1'b0);
  endtask

  task automatic bus_stop();
    drive_bus(SclLow, 1'b0);
    drive_bus(SclRise, 1'b0);
    drive_bus(SclHigh, 1'b0);
    drive_bus(SclHigh, 1'b1);
  endtask

  // Drain all results and let the block settle before a register write
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Edges while idle or stopped are ignored; steady high detects start/stop
  task automatic test_idle_and_conditions();
    drive_bus(SclRise, 1'b1);
    drive_bus(SclFall, 1'b0);
    drive_bus(SclLow, 1'b1);
    drive_bus(SclHigh, 1'b1);
    drive_bus(SclHigh, 1'b0);
    drive_bus(SclHigh, 1'b1);
    drive_bus(SclRise, 1'b0);
    drive_bus(SclFall, 1'b1);
  endtask

  // Write to address zero; SDA toggles while the ack is held count as stop and start
  task automatic test_write_frame();
    bus_start();
    clock_byte(8'h00, 1'b1);
    drive_bus(SclHigh, 1'b1);
    drive_bus(SclHigh, 1'b0);
    drive_bus(SclFall, 1'b0);
    clock_bit(1'b0, 1'b1);
    clock_byte(8'hFF, 1'b1);
    clock_bit(1'b0, 1'b1);
    clock_byte(8'h00, 1'b1);
    clock_bit(1'b0, 1'b1);
    bus_stop();
  endtask

  // Read from the top address, one ACKed byte, then a NACK ends it
  task automatic test_read_frame();
    wait_idle();
    write_register(CfgOwnAddress, 7'h7F);
    bus_start();
    clock_byte({7'h7F, 1'b1}, 1'b1);
    clock_bit(1'b0, 1'b1);
    clock_byte(8'($urandom), 1'b1);
    clock_bit(1'b0, 1'b1);
    clock_byte(8'($urandom), 1'b1);
    clock_bit(1'b1, 1'b1);
    clock_bit(1'b0, 1'b1);
    bus_stop();
  endtask

  // Wrong address drops the target until the next start
  task automatic test_address_mismatch();
    bus_start();
    clock_byte({7'h2A, 1'b0}, 1'b1);
    clock_bit(1'b0, 1'b1);
    clock_bit(1'b1, 1'b1);
    bus_start();
    clock_byte({7'h7F, 1'b0}, 1'b1);
    bus_stop();
  endtask

  // Disabled target ignores everything and keeps its SDA drive
  task automatic test_disabled();
    wait_idle();
    write_register(CfgEnabled, 7'd0);
    bus_start();
    clock_bit(1'b1, 1'b0);
    bus_stop();
    wait_idle();
    write_register(CfgEnabled, {6'($urandom), 1'b1});
  endtask

  // Hold the receiver off while samples keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_out = 1'b1;
    bus_start();
    clock_byte({cfg_addr, 1'b0}, 1'b1);
    clock_bit(1'b0, 1'b1);
    while (hold_out) @(posedge clk_i);
    wait_idle();
  endtask

  // Mostly well-formed transfers with random content, some noise and cuts
  task automatic random_bus_transaction();
    logic [AddrBits-1:0] addr;
    logic                rw;
    bit                  compact;
    int unsigned         nbytes;
    compact = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 6))
        send_sample(scl_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    8'($urandom));
    bus_start();
    addr = ($urandom_range(0, 4) != 0) ? cfg_addr : 7'($urandom);
    rw = 1'($urandom_range(0, 1));
    clock_byte({addr, rw}, compact);
    clock_bit(1'b0, compact);
    nbytes = $urandom_range(0, 2);
    for (int k = 0; k < nbytes; k++) begin
      if ($urandom_range(0, 19) == 0) break;
      clock_byte(8'($urandom), compact);
      if (rw) clock_bit((k == nbytes - 1) ? 1'b1 : 1'b0, compact);
      else clock_bit(1'b0, compact);
    end
    if ($urandom_range(0, 3) != 0) begin
      bus_stop();
    end else begin
      drive_bus(SclLow, 1'b1);
      drive_bus(SclRise, 1'b1);
    end
  endtask

  // Rounds of random traffic over address extremes, random addresses,
  // a gap-free stretch and a disabled stretch
  task automatic test_random_traffic();
    int unsigned round_start;
    for (int r = 0; r < 5; r++) begin
      wait_idle();
      case (r)
        0:       write_register(CfgOwnAddress, 7'h00);
        1:       write_register(CfgOwnAddress, 7'h7F);
        default: write_register(CfgOwnAddress, 7'($urandom));
      endcase
      no_idle = (r == 2);
      if (r == 3) begin
        write_register(CfgEnabled, 7'd0);
        random_bus_transaction();
        wait_idle();
        write_register(CfgEnabled, 7'd1);
      end
      round_start = samples_sent;
      while (samples_sent - round_start < RoundItems) random_bus_transaction();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_and_conditions();
    test_write_frame();
    test_read_frame();
    test_address_mismatch();
    test_disabled();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch("missing results, count", 8'd0, 8'(awaited_results.size()));
    if (error_count == 0) begin
      $display("** i2c_target_byte_engine: PASSED **");
    end else begin
      $display("** i2c_target_byte_engine: FAILED **");
    end
    $finish;
  end

endmodule
